/* rtl/ndsp_pkg.sv */
// Shared types, constants and decode functions for the DVEXT sentence parser.
// No dependencies; every other file in rtl/ imports this package.
package ndsp_pkg;

    localparam int FIELD_COUNT_DEF     = 34;
    localparam int FRACTION_DIGITS_DEF = 3;
    localparam int VALUE_WIDTH_DEF     = 32;

    // Only fields 0 to 33 carry data; higher field numbers are skipped.
    localparam int NUM_SLOTS = 34;
    localparam int SLOT_W    = 6;

    localparam logic [SLOT_W-1:0] IMU_FIELD  = 6'd2;
    localparam logic [SLOT_W-1:0] LAST_FIELD = 6'd33;

    localparam logic [11:0] ALL_UNKNOWN = 12'h924;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_T      = 8'h54;

    localparam logic [1:0] IMU_OK    = 2'd1;
    localparam logic [1:0] IMU_WARN  = 2'd2;
    localparam logic [1:0] IMU_ERROR = 2'd3;

    typedef enum logic [2:0] {
        PH_WAIT, PH_SKIP, PH_TYPE, PH_SEP, PH_FIELDS, PH_TAIL, PH_CHECK0, PH_CHECK1
    } t_phase;

    typedef enum logic [2:0] {
        ST_PARSE, ST_PAD, ST_CLOSE, ST_RUN_RD, ST_RUN_EMIT
    } t_ctrl_state;

    typedef enum logic [2:0] {
        K_NONE, K_LOCK, K_IMU, K_INT, K_GAIN, K_DEC
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_sentence;
    } t_in_item;

    typedef struct packed {
        logic [5:0]        field_number;
        logic signed [31:0] field_value;
        logic [1:0]        imu_status;
        logic [2:0]        system_calibration;
        logic [2:0]        gyro_calibration;
        logic [2:0]        accel_calibration;
        logic [2:0]        magnet_calibration;
        logic              last_of_run;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic pad;
        logic close;
        logic run_next;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_pad;
        logic run_go;
        logic pad_done;
        logic f_none;
        logic f_last;
        logic out_free;
    } t_status;

    function automatic t_kind kind_of(input logic [6:0] f);
        t_kind k;
        k = K_NONE;
        if (f == 7'd0) k = K_LOCK;
        else if (f == 7'd2) k = K_IMU;
        else if (f >= 7'd3 && f <= 7'd5) k = K_DEC;
        else if (f == 7'd6) k = K_INT;
        else if (f >= 7'd8 && f <= 7'd10) k = K_DEC;
        else if (f >= 7'd18 && f <= 7'd21) k = K_GAIN;
        else if (f >= 7'd22 && f <= 7'd25) k = K_LOCK;
        else if (f >= 7'd26 && f <= 7'd33) k = K_DEC;
        return k;
    endfunction

    function automatic logic [7:0] type_char(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h44; // D
            3'd1:    ch = 8'h56; // V
            3'd2:    ch = 8'h45; // E
            3'd3:    ch = 8'h58; // X
            default: ch = 8'h54; // T
        endcase
        return ch;
    endfunction

    // Hex digit value; bit 4 set means the character is not a hex digit.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] h;
        if (c >= 8'h30 && c <= 8'h39) h = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) h = 5'(c - 8'h37);
        else if (c >= 8'h61 && c <= 8'h66) h = 5'(c - 8'h57);
        else h = 5'd16;
        return h;
    endfunction

endpackage

/* rtl/ndsp_ctrl.sv */
// Controller state machine of the DVEXT sentence parser.
// Depends on ndsp_pkg; drives the datapath through t_cmd and reads t_status.
module ndsp_ctrl
    import ndsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PARSE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_PARSE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_valid;
                if (i_valid) begin
                    if (i_status.run_go) n_state = ST_RUN_RD;
                    else if (i_status.need_pad) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                o_cmd.pad = 1'b1;
                if (i_status.pad_done) n_state = ST_CLOSE;
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
                n_state     = ST_PARSE;
            end
            ST_RUN_RD: begin
                if (i_status.f_none) o_cmd.run_next = 1'b1;
                else n_state = ST_RUN_EMIT;
            end
            ST_RUN_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_status.f_last ? ST_PARSE : ST_RUN_RD;
                end
            end
            default: n_state = ST_PARSE;
        endcase
    end

endmodule

/* rtl/ndsp_datapath.sv */
// Datapath of the DVEXT sentence parser: byte parsing, field decode, the pending
// and committed value memories and the output register. Depends on ndsp_pkg.
module ndsp_datapath
    import ndsp_pkg::*;
#(
    parameter int FIELD_COUNT     = FIELD_COUNT_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_data,
    input  t_cmd      i_cmd,
    input  logic      i_out_stall,
    output t_status   o_status,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    localparam int VW  = VALUE_WIDTH;
    localparam int FCW = $clog2(FIELD_COUNT + 1);
    localparam logic [VW-1:0]   CAP      = VW'(1) << (VW - 1);
    localparam logic [VW+3:0]   CAP_WIDE = (VW + 4)'(CAP);
    localparam logic [FCW-1:0]  FC_LAST  = FCW'(FIELD_COUNT - 1);
    localparam logic [3:0]      FD       = 4'(FRACTION_DIGITS);

    // Parse state
    t_phase             r_phase, n_phase;
    logic [7:0]         r_xor, n_xor;
    logic [7:0]         r_rc, n_rc;
    logic [2:0]         r_tcnt, n_tcnt;
    logic [FCW-1:0]     r_fcnt, n_fcnt;
    logic [VW-1:0]      r_acc, n_acc;
    logic               r_neg, n_neg;
    logic               r_digit, n_digit;
    logic               r_frac, n_frac;
    logic               r_done, n_done;
    logic               r_start, n_start;
    logic [2:0]         r_nfrac, n_nfrac;
    logic [2:0]         r_imu_cnt, n_imu_cnt;
    logic [11:0]        r_imu_chars, n_imu_chars;
    logic               r_err, n_err;
    logic [NUM_SLOTS-1:0] r_present, n_present;
    logic [13:0]        r_pimu, n_pimu;

    // Commit side
    logic [13:0]          r_cimu;
    logic [NUM_SLOTS-1:0] r_cvalid;
    logic [SLOT_W-1:0]    r_fidx;
    logic [VW-1:0]        r_pend_rd, r_comm_rd;
    logic [VW-1:0]        pend_mem [NUM_SLOTS];
    logic [VW-1:0]        comm_mem [NUM_SLOTS];
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [7:0]      c;
    logic            eos;
    t_kind           k_cur;
    logic            is_digit;
    logic [3:0]      push_d;
    logic [VW+3:0]   push_wide;
    logic [VW-1:0]   push_out;
    logic            pad_raw;
    logic            do_close;
    logic            run_go;
    logic [4:0]      hv;
    logic [SLOT_W-1:0] slot;
    logic [VW-1:0]   neg_v, pos_v, num_v, gain_v;
    logic            imu_warn;
    logic [13:0]     imu_v;
    logic            pend_we;
    logic [VW-1:0]   pend_wdata;
    logic [VW-1:0]   emit_val;
    logic            out_free;

    assign c        = i_data.data_byte;
    assign eos      = i_data.end_of_sentence;
    assign k_cur    = kind_of(7'(r_fcnt));
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign hv       = hex_val(c);
    assign slot     = SLOT_W'(r_fcnt);

    // Saturating multiply by ten and add, shared by digit entry and padding.
    assign push_d    = i_cmd.pad ? 4'd0 : c[3:0];
    assign push_wide = ((VW + 4)'(r_acc) << 3) + ((VW + 4)'(r_acc) << 1) + (VW + 4)'(push_d);
    assign push_out  = (push_wide > CAP_WIDE) ? CAP : push_wide[VW-1:0];

    // A decimal field with fewer fraction digits than required is padded first.
    assign pad_raw = (k_cur == K_DEC) && r_digit && ({1'b0, r_nfrac} < FD);

    // Field close values
    assign neg_v  = VW'(0) - r_acc;
    assign pos_v  = (r_acc >= CAP) ? (CAP - VW'(1)) : r_acc;
    assign num_v  = r_neg ? neg_v : pos_v;
    assign gain_v = VW'($signed(num_v[7:0]));

    always_comb begin
        imu_warn = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r_imu_chars[3*i +: 3] < 3'd2) imu_warn = 1'b1;
        end
        if (r_imu_cnt != 3'd4) imu_v = {r_cimu[13:2], IMU_ERROR};
        else imu_v = {r_imu_chars, imu_warn ? IMU_WARN : IMU_OK};
    end

    always_comb begin
        n_phase     = r_phase;
        n_xor       = r_xor;
        n_rc        = r_rc;
        n_tcnt      = r_tcnt;
        n_fcnt      = r_fcnt;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_digit     = r_digit;
        n_frac      = r_frac;
        n_done      = r_done;
        n_start     = r_start;
        n_nfrac     = r_nfrac;
        n_imu_cnt   = r_imu_cnt;
        n_imu_chars = r_imu_chars;
        n_err       = r_err;
        n_present   = r_present;
        n_pimu      = r_pimu;
        do_close    = 1'b0;
        run_go      = 1'b0;
        pend_we     = 1'b0;
        pend_wdata  = r_acc;

        if (i_cmd.take) begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (c == CH_DOLLAR) begin
                        n_xor       = '0;
                        n_rc        = '0;
                        n_tcnt      = '0;
                        n_fcnt      = '0;
                        n_present   = '0;
                        n_err       = 1'b0;
                        n_acc       = '0;
                        {n_neg, n_digit, n_frac, n_done, n_start} = '0;
                        n_nfrac     = '0;
                        n_imu_cnt   = '0;
                        n_imu_chars = ALL_UNKNOWN;
                        n_phase     = PH_TYPE;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_TYPE: begin
                    n_xor = r_xor ^ c;
                    if (c == type_char(r_tcnt)) begin
                        n_tcnt = r_tcnt + 3'd1;
                        if (r_tcnt == 3'd4) n_phase = PH_SEP;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_SEP: begin
                    if (c == CH_STAR) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_xor   = r_xor ^ c;
                        n_phase = PH_FIELDS;
                    end
                end
                PH_FIELDS: begin
                    if (c == CH_STAR) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_xor = r_xor ^ c;
                        if (c == CH_COMMA) begin
                            if (eos || !pad_raw) do_close = 1'b1;
                        end else begin
                            n_start = 1'b1;
                            if (k_cur == K_LOCK) begin
                                if (!r_start) n_acc = VW'(c == CH_T);
                            end else if (k_cur == K_IMU) begin
                                if (r_imu_cnt < 3'd4) begin
                                    n_imu_chars[3*r_imu_cnt[1:0] +: 3] =
                                        (c >= CH_ZERO && c <= CH_THREE) ? {1'b0, c[1:0]} : 3'd4;
                                end
                                if (r_imu_cnt < 3'd5) n_imu_cnt = r_imu_cnt + 3'd1;
                            end else if (k_cur != K_NONE && !r_done) begin
                                if (!r_start && (c == CH_MINUS || c == CH_PLUS)) begin
                                    if (c == CH_MINUS) n_neg = 1'b1;
                                end else if (is_digit) begin
                                    if (!r_frac) begin
                                        n_acc = push_out;
                                    end else if ({1'b0, r_nfrac} < FD) begin
                                        n_acc   = push_out;
                                        n_nfrac = r_nfrac + 3'd1;
                                    end
                                    n_digit = 1'b1;
                                end else if (c == CH_POINT && k_cur == K_DEC && !r_frac) begin
                                    n_frac = 1'b1;
                                end else begin
                                    n_done = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_TAIL: begin
                    if (c == CH_STAR) n_phase = PH_CHECK0;
                    else n_xor = r_xor ^ c;
                end
                PH_CHECK0, PH_CHECK1: begin
                    if (hv[4] || (r_rc > 8'h0F)) n_err = 1'b1;
                    else n_rc = {r_rc[3:0], hv[3:0]};
                    n_phase = PH_CHECK1;
                end
                default: ;
            endcase
        end

        if (i_cmd.pad) begin
            n_acc   = push_out;
            n_nfrac = r_nfrac + 3'd1;
        end

        if (i_cmd.close) do_close = 1'b1;

        if (do_close) begin
            if (r_start && k_cur != K_NONE) begin
                if (k_cur == K_IMU) begin
                    n_pimu                = imu_v;
                    n_present[IMU_FIELD]  = 1'b1;
                end else if (k_cur != K_LOCK && !r_digit) begin
                    n_err = 1'b1;
                end else begin
                    pend_we         = 1'b1;
                    pend_wdata      = (k_cur == K_LOCK) ? r_acc :
                                      (k_cur == K_GAIN) ? gain_v : num_v;
                    n_present[slot] = 1'b1;
                end
            end
            n_acc       = '0;
            {n_neg, n_digit, n_frac, n_done, n_start} = '0;
            n_nfrac     = '0;
            n_imu_cnt   = '0;
            n_imu_chars = ALL_UNKNOWN;
            n_fcnt      = r_fcnt + FCW'(1);
            if (r_fcnt >= FC_LAST) n_phase = PH_TAIL;
        end

        if (i_cmd.take && eos) begin
            run_go  = (n_phase == PH_CHECK1) && !n_err && (n_rc == n_xor);
            n_phase = PH_WAIT;
        end
    end

    // Commit run value: fresh pending value, else the old committed one, else zero; always zero for the IMU field.
    always_comb begin
        if (r_fidx == IMU_FIELD) emit_val = '0;
        else if (r_present[r_fidx]) emit_val = r_pend_rd;
        else if (r_cvalid[r_fidx]) emit_val = r_comm_rd;
        else emit_val = '0;
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_xor       <= '0;
            r_rc        <= '0;
            r_tcnt      <= '0;
            r_fcnt      <= '0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_digit     <= 1'b0;
            r_frac      <= 1'b0;
            r_done      <= 1'b0;
            r_start     <= 1'b0;
            r_nfrac     <= '0;
            r_imu_cnt   <= '0;
            r_imu_chars <= ALL_UNKNOWN;
            r_err       <= 1'b0;
            r_present   <= '0;
            r_cimu      <= {ALL_UNKNOWN, 2'd0};
            r_cvalid    <= '0;
            r_fidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_xor       <= n_xor;
            r_rc        <= n_rc;
            r_tcnt      <= n_tcnt;
            r_fcnt      <= n_fcnt;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_digit     <= n_digit;
            r_frac      <= n_frac;
            r_done      <= n_done;
            r_start     <= n_start;
            r_nfrac     <= n_nfrac;
            r_imu_cnt   <= n_imu_cnt;
            r_imu_chars <= n_imu_chars;
            r_err       <= n_err;
            r_present   <= n_present;
            if (run_go) begin
                r_fidx <= '0;
                if (r_present[IMU_FIELD]) r_cimu <= r_pimu;
            end
            if (i_cmd.run_next || (i_cmd.emit && r_fidx != LAST_FIELD)) begin
                r_fidx <= r_fidx + SLOT_W'(1);
            end
            if (i_cmd.emit) begin
                r_cvalid[r_fidx] <= 1'b1;
                r_out_valid      <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers and memories
    always_ff @(posedge i_clk) begin
        r_pimu <= n_pimu;
        if (pend_we) pend_mem[slot] <= pend_wdata;
        r_pend_rd <= pend_mem[r_fidx];
        if (i_cmd.emit) comm_mem[r_fidx] <= emit_val;
        r_comm_rd <= comm_mem[r_fidx];
        if (i_cmd.emit) begin
            r_out.field_number       <= r_fidx;
            r_out.field_value        <= 32'($signed(emit_val));
            r_out.imu_status         <= r_cimu[1:0];
            r_out.system_calibration <= r_cimu[4:2];
            r_out.gyro_calibration   <= r_cimu[7:5];
            r_out.accel_calibration  <= r_cimu[10:8];
            r_out.magnet_calibration <= r_cimu[13:11];
            r_out.last_of_run        <= (r_fidx == LAST_FIELD);
        end
    end

    always_comb begin
        o_status.need_pad = (r_phase == PH_FIELDS) && (c == CH_COMMA) && !eos && pad_raw;
        o_status.run_go   = run_go;
        o_status.pad_done = ({1'b0, r_nfrac} + 4'd1) >= FD;
        o_status.f_none   = (kind_of(7'(r_fidx)) == K_NONE);
        o_status.f_last   = (r_fidx == LAST_FIELD);
        o_status.out_free = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/nmea_dvl_sentence_parser.sv */
// Top level of the DVEXT sentence parser: controller plus datapath.
// Depends on ndsp_pkg, ndsp_ctrl and ndsp_datapath.
//
// Usage: sentence bytes enter on the input channel (i_valid, o_stall,
// i_data), one transfer per byte, with end_of_sentence set on the last
// byte. A byte is taken when i_valid is high and o_stall is low.
// Results leave on the output channel (o_valid, i_stall, o_data); a result
// is taken when o_valid is high and i_stall is low.
// Throughput: one byte per cycle while a sentence streams in. A comma that
// closes a decimal field with fewer fraction digits than FRACTION_DIGITS
// holds the input while one zero is appended per missing digit and then
// while the field is closed.
// When the final byte completes a sentence whose checksum matches, the
// pending fields are committed and 25 results follow, one per reported
// field in field order, the last one flagged by last_of_run. Each result
// is a memory read, then a load of the output register, and the nine
// unreported field slots are stepped over one at a time; input is held
// off for the whole run. A stalled receiver holds the output register and
// the run.
// Bad or incomplete sentences give no results and commit nothing.
// Reset (synchronous, active low) clears all committed values to zero and
// the IMU state to stale with all levels unknown.
module nmea_dvl_sentence_parser
    import ndsp_pkg::*;
#(
    parameter int FIELD_COUNT     = FIELD_COUNT_DEF,
    parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF,
    parameter int VALUE_WIDTH     = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_data,
    output logic      o_stall,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_cmd    cmd;
    t_status status;

    // The controller sequences parsing, padding, field close and the commit run.
    ndsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_status   (status),
        .o_in_stall (o_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds all sentence state, both value stores and the output register.
    ndsp_datapath #(
        .FIELD_COUNT     (FIELD_COUNT),
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .VALUE_WIDTH     (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (i_data),
        .i_cmd       (cmd),
        .i_out_stall (i_stall),
        .o_status    (status),
        .o_out_valid (o_valid),
        .o_out_data  (o_data)
    );

endmodule

/* rtl/ndsp_checker.sv */
// Port-level checker for the DVEXT sentence parser, bound to the top level.
// Depends on ndsp_pkg and nmea_dvl_sentence_parser.
module ndsp_checker
    import ndsp_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_in_item  i_data,
    input logic      o_stall,
    input logic      o_valid,
    input t_out_item o_data,
    input logic      i_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.field_number <= LAST_FIELD)
        else $error("field number out of range");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_of_run == (o_data.field_number == LAST_FIELD)))
        else $error("last_of_run not on final field");

    a_imu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.field_number == IMU_FIELD |-> o_data.field_value == 32'sd0)
        else $error("IMU field result carries a value");

endmodule

bind nmea_dvl_sentence_parser ndsp_checker u_ndsp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .i_data  (i_data),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .o_data  (o_data),
    .i_stall (i_stall)
);
